[rtl/capavg_pkg.sv]
// Shared types and constants for the capacitance averaging front end.
// No dependencies; every other file refers to this package by scoped names.
package capavg_pkg;

	// Field widths of the request and result channels.
	localparam int CODE_BYTE_W = 8;
	localparam int CODE_W      = 16;
	localparam int CAP_W       = 19;
	localparam int LEVEL_W     = 5;
	localparam int WORD_W      = 16;

	// Configuration register widths and the write port data width.
	localparam int CHAN_W      = 2;
	localparam int RATE_W      = 2;
	localparam int AF_W        = 10;
	localparam int STEP_W      = 12;
	localparam int THRESH_W    = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration register indexes on the write port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSOR_CHANNEL     = 3'd0,
		CFG_SAMPLE_RATE_CODE   = 3'd1,
		CFG_ATTOFARAD_PER_CODE = 3'd2,
		CFG_OFFSET_STEP_FF     = 3'd3,
		CFG_UPPER_THRESHOLD    = 3'd4,
		CFG_LOWER_THRESHOLD    = 3'd5,
		CFG_OFFSET_LEVEL_MAX   = 3'd6
	} cfg_index_t;

	// Register values after reset.
	localparam logic [CHAN_W-1:0]   RST_SENSOR_CHANNEL     = 2'd0;
	localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE_CODE   = 2'd1;
	localparam logic [AF_W-1:0]     RST_ATTOFARAD_PER_CODE = 10'd488;
	localparam logic [STEP_W-1:0]   RST_OFFSET_STEP_FF     = 12'd3125;
	localparam logic [THRESH_W-1:0] RST_UPPER_THRESHOLD    = 8'd112;
	localparam logic [THRESH_W-1:0] RST_LOWER_THRESHOLD    = 8'd16;
	localparam logic [LEVEL_W-1:0]  RST_OFFSET_LEVEL_MAX   = 5'd31;

	// Default depth of the averaging window.
	localparam int WINDOW_SIZE_DEF = 8;

	// Code magnitude times attofarads per code, and the offset term.
	localparam int PROD_W = CODE_W + AF_W;
	localparam int OFFS_W = STEP_W + LEVEL_W;

	// Attofarad to femtofarad scaling: divide by 1000 through a rounded-up
	// reciprocal. The error term stays below 2^10, so for products below
	// 2^26 the high part of the multiplication is the exact quotient.
	localparam int          AF_PER_FF    = 1000;
	localparam int          CODE_DIV_SH  = PROD_W + 10;
	localparam int          CODE_DIV_M_W = PROD_W + 1;
	localparam logic [63:0] CODE_DIV_M64 =
		((64'd1 << CODE_DIV_SH) + 64'(AF_PER_FF - 1)) / 64'(AF_PER_FF);
	localparam logic [CODE_DIV_M_W-1:0] CODE_DIV_MUL = CODE_DIV_M64[CODE_DIV_M_W-1:0];
	localparam int          CODE_DIV_P_W = PROD_W + CODE_DIV_M_W;
	localparam int          QUOT_W       = 16;

	// Configuration and trigger word layout.
	localparam int            CFG_CHAN_SHIFT  = 13;
	localparam logic [2:0]    CFG_FIXED_CODE  = 3'h4;
	localparam int            CFG_FIXED_SHIFT = 10;
	localparam int            CFG_LEVEL_SHIFT = 5;
	localparam int            TRIG_RATE_SHIFT = 10;
	localparam logic [2:0]    TRIG_BIT_TOP    = 3'd7;

	// Controls handed from the pipeline to the window unit.
	typedef struct packed {
		logic adv;
		logic push;
	} win_ctrl_t;

endpackage

[rtl/capavg_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on capavg_pkg for default sizes.
module capavg_ram #(
	parameter int WIDTH = capavg_pkg::CAP_W,
	parameter int DEPTH = capavg_pkg::WINDOW_SIZE_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the address being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/capavg_window.sv]
// Moving window of capacitance samples: store, running sum and average.
// Depends on capavg_pkg and instantiates capavg_ram for the sample store.
module capavg_window #(
	parameter int WINDOW_SIZE = capavg_pkg::WINDOW_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  capavg_pkg::win_ctrl_t             ctrl,
	input  logic signed [capavg_pkg::CAP_W-1:0] cap,
	output logic signed [capavg_pkg::CAP_W-1:0] average
);

	localparam int CAP_W   = capavg_pkg::CAP_W;
	localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int SUM_W   = CAP_W + SLOT_W;
	localparam int DIV_L   = $clog2(WINDOW_SIZE);
	localparam int DIV_SH  = SUM_W + DIV_L;
	localparam int MUL_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + MUL_W;
	localparam logic [63:0] AVG_M64 =
		((64'd1 << DIV_SH) + 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE);
	localparam logic [MUL_W-1:0] AVG_MUL = AVG_M64[MUL_W-1:0];
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);

	logic [SLOT_W-1:0]       slot_q;
	logic [SLOT_W-1:0]       slot_nxt;
	logic [SLOT_W-1:0]       rd_addr;
	logic [WINDOW_SIZE-1:0]  valid_q;
	logic                    fwd_q;
	logic [CAP_W-1:0]        fwd_data_q;
	logic [CAP_W-1:0]        rd_data;
	logic signed [CAP_W-1:0] old_cap;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [SUM_W-1:0]        mag_s6;
	logic                    neg_s6;
	logic [PROD_W-1:0]       avg_prod;
	logic [CAP_W-1:0]        quot_s7;
	logic                    neg_s7;

	// Slot counter wraps at the window size.
	assign slot_nxt = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

	// Read ahead the slot that the next request will replace.
	assign rd_addr = ctrl.push ? slot_nxt : slot_q;

	capavg_ram #(
		.WIDTH (CAP_W),
		.DEPTH (WINDOW_SIZE)
	) u_store (
		.clk     (clk),
		.wr_en   (ctrl.push),
		.wr_addr (slot_q),
		.wr_data (cap),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entries never written count as zero; a one-entry window reads back
	// the value written in the previous cycle.
	always_comb begin
		if (!valid_q[slot_q]) begin
			old_cap = '0;
		end else if (fwd_q) begin
			old_cap = $signed(fwd_data_q);
		end else begin
			old_cap = $signed(rd_data);
		end
	end

	assign sum_nxt = sum_q - SUM_W'(old_cap) + SUM_W'(cap);

	// Window bookkeeping; the running sum doubles as the stage 5 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= '0;
			sum_q   <= '0;
			fwd_q   <= 1'b0;
		end else begin
			fwd_q <= ctrl.push && (slot_nxt == slot_q);
			if (ctrl.push) begin
				slot_q          <= slot_nxt;
				valid_q[slot_q] <= 1'b1;
				sum_q           <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= cap;
	end

	// Sign and magnitude, then division by the window size through a
	// reciprocal multiplication.
	assign avg_prod = PROD_W'(mag_s6) * PROD_W'(AVG_MUL);

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			neg_s6  <= sum_q[SUM_W-1];
			mag_s6  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			neg_s7  <= neg_s6;
			quot_s7 <= avg_prod[DIV_SH +: CAP_W];
		end
	end

	// Restore the sign; the result truncates toward zero.
	assign average = neg_s7 ? -$signed(quot_s7) : $signed(quot_s7);

endmodule

[rtl/capavg_window_top_note.sv]
// Offset level control for the capacitance averaging front end.
// Depends on capavg_pkg; used by the top level at request acceptance.
module capavg_level (
	input  logic [capavg_pkg::THRESH_W-1:0] code_high,
	input  logic [capavg_pkg::THRESH_W-1:0] upper_threshold,
	input  logic [capavg_pkg::THRESH_W-1:0] lower_threshold,
	input  logic [capavg_pkg::LEVEL_W-1:0]  level_max,
	input  logic [capavg_pkg::LEVEL_W-1:0]  level,
	output logic [capavg_pkg::LEVEL_W-1:0]  level_next
);

	// Raising is tested first; each move stops at its limit.
	always_comb begin
		level_next = level;
		priority if (code_high > upper_threshold) begin
			if (level < level_max) begin
				level_next = level + 1'b1;
			end
		end else if (code_high < lower_threshold) begin
			if (level != '0) begin
				level_next = level - 1'b1;
			end
		end else begin
			// Between the thresholds the level holds.
			level_next = level;
		end
	end

endmodule

[rtl/capacdac_autorange_capacitance_average.sv]
// Top level of the capacitance front end: pipeline, registers and words.
// Depends on capavg_pkg, capavg_level, capavg_window and capavg_ram.
//
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  code_high, code_low
// result    out        out_valid/out_stall  capacitance_ff, average_ff,
//                                           offset_level_next, config_word,
//                                           trigger_word
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// One request is accepted every cycle while in_stall is low; each result is
// registered through the multiply and divide pipeline and the result register.
// Reset clears the offset level, the window valid bits, the running sum and
// all valid flags; no clearing pass is needed.
// The whole pipeline holds while a result waits under out_stall, so
// in_stall follows out_stall in that cycle.
module capdac_autorange_capacitance_average #(
	parameter int WINDOW_SIZE = capavg_pkg::WINDOW_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [capavg_pkg::CODE_BYTE_W-1:0]     code_high,
	input  logic [capavg_pkg::CODE_BYTE_W-1:0]     code_low,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [capavg_pkg::CAP_W-1:0]    capacitance_ff,
	output logic signed [capavg_pkg::CAP_W-1:0]    average_ff,
	output logic [capavg_pkg::LEVEL_W-1:0]         offset_level_next,
	output logic [capavg_pkg::WORD_W-1:0]          config_word,
	output logic [capavg_pkg::WORD_W-1:0]          trigger_word,
	input  logic                                   cfg_wr_en,
	input  logic [capavg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [capavg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CODE_W  = capavg_pkg::CODE_W;
	localparam int CAP_W   = capavg_pkg::CAP_W;
	localparam int LEVEL_W = capavg_pkg::LEVEL_W;
	localparam int WORD_W  = capavg_pkg::WORD_W;
	localparam int PROD_W  = capavg_pkg::PROD_W;
	localparam int OFFS_W  = capavg_pkg::OFFS_W;
	localparam int QUOT_W  = capavg_pkg::QUOT_W;
	localparam int DP_W    = capavg_pkg::CODE_DIV_P_W;

	// Configuration registers.
	logic [capavg_pkg::CHAN_W-1:0]   sensor_channel_q;
	logic [capavg_pkg::RATE_W-1:0]   sample_rate_code_q;
	logic [capavg_pkg::AF_W-1:0]     attofarad_per_code_q;
	logic [capavg_pkg::STEP_W-1:0]   offset_step_ff_q;
	logic [capavg_pkg::THRESH_W-1:0] upper_threshold_q;
	logic [capavg_pkg::THRESH_W-1:0] lower_threshold_q;
	logic [LEVEL_W-1:0]              offset_level_max_q;

	logic [LEVEL_W-1:0] offset_level_q;
	logic [LEVEL_W-1:0] level_nxt;
	logic               adv;
	logic               accept;

	logic [CODE_W-1:0]  raw_code;
	logic [CODE_W-1:0]  v_s;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [CODE_W-1:0]       mag_s1;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [LEVEL_W-1:0]      lvl_cur_s1;
	logic [LEVEL_W-1:0]      lvl_s1, lvl_s2, lvl_s3, lvl_s4, lvl_s5, lvl_s6, lvl_s7;
	logic [PROD_W-1:0]       pmag_s2;
	logic [OFFS_W-1:0]       offs_s2, offs_s3;
	logic [DP_W-1:0]         div_prod;
	logic [QUOT_W-1:0]       quot_s3;
	logic signed [CAP_W-1:0] quot_ext;
	logic signed [CAP_W-1:0] cap_nxt;
	logic signed [CAP_W-1:0] cap_s4, cap_s5, cap_s6, cap_s7;
	logic signed [CAP_W-1:0] average;
	capavg_pkg::win_ctrl_t   win_ctrl;

	logic                    out_valid_q;
	logic signed [CAP_W-1:0] cap_out_q;
	logic signed [CAP_W-1:0] avg_out_q;
	logic [LEVEL_W-1:0]      lvl_out_q;
	logic [WORD_W-1:0]       cfg_word_q;
	logic [WORD_W-1:0]       trig_word_q;
	logic [WORD_W-1:0]       cfg_word_nxt;
	logic [WORD_W-1:0]       trig_word_nxt;

	// The pipeline moves as a whole whenever the result register is free.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_channel_q     <= capavg_pkg::RST_SENSOR_CHANNEL;
			sample_rate_code_q   <= capavg_pkg::RST_SAMPLE_RATE_CODE;
			attofarad_per_code_q <= capavg_pkg::RST_ATTOFARAD_PER_CODE;
			offset_step_ff_q     <= capavg_pkg::RST_OFFSET_STEP_FF;
			upper_threshold_q    <= capavg_pkg::RST_UPPER_THRESHOLD;
			lower_threshold_q    <= capavg_pkg::RST_LOWER_THRESHOLD;
			offset_level_max_q   <= capavg_pkg::RST_OFFSET_LEVEL_MAX;
		end else if (cfg_wr_en) begin
			unique case (capavg_pkg::cfg_index_t'(cfg_index))
				capavg_pkg::CFG_SENSOR_CHANNEL: begin
					sensor_channel_q <= cfg_data[capavg_pkg::CHAN_W-1:0];
				end
				capavg_pkg::CFG_SAMPLE_RATE_CODE: begin
					sample_rate_code_q <= cfg_data[capavg_pkg::RATE_W-1:0];
				end
				capavg_pkg::CFG_ATTOFARAD_PER_CODE: begin
					attofarad_per_code_q <= cfg_data[capavg_pkg::AF_W-1:0];
				end
				capavg_pkg::CFG_OFFSET_STEP_FF: begin
					offset_step_ff_q <= cfg_data[capavg_pkg::STEP_W-1:0];
				end
				capavg_pkg::CFG_UPPER_THRESHOLD: begin
					upper_threshold_q <= cfg_data[capavg_pkg::THRESH_W-1:0];
				end
				capavg_pkg::CFG_LOWER_THRESHOLD: begin
					lower_threshold_q <= cfg_data[capavg_pkg::THRESH_W-1:0];
				end
				capavg_pkg::CFG_OFFSET_LEVEL_MAX: begin
					offset_level_max_q <= cfg_data[LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Offset level moves at acceptance; the request keeps the level it saw.
	capavg_level u_level (
		.code_high       (code_high),
		.upper_threshold (upper_threshold_q),
		.lower_threshold (lower_threshold_q),
		.level_max       (offset_level_max_q),
		.level           (offset_level_q),
		.level_next      (level_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_level_q <= '0;
		end else if (accept) begin
			offset_level_q <= level_nxt;
		end
	end

	// Valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// Stage 1: signed code taken apart into sign and magnitude.
	assign raw_code = {code_high, code_low};
	assign v_s      = raw_code[CODE_W-1] ? CODE_W'(-raw_code) : raw_code;

	// Stage 3 input: exact division of the product magnitude by 1000.
	assign div_prod = DP_W'(pmag_s2) * DP_W'(capavg_pkg::CODE_DIV_MUL);

	// Stage 4 input: signed quotient plus the offset contribution.
	assign quot_ext = CAP_W'(quot_s3);
	assign cap_nxt  = (neg_s3 ? -quot_ext : quot_ext) + $signed(CAP_W'(offs_s3));

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1     <= v_s;
			neg_s1     <= raw_code[CODE_W-1];
			lvl_cur_s1 <= offset_level_q;
			lvl_s1     <= level_nxt;

			pmag_s2 <= PROD_W'(mag_s1) * PROD_W'(attofarad_per_code_q);
			offs_s2 <= OFFS_W'(offset_step_ff_q) * OFFS_W'(lvl_cur_s1);
			neg_s2  <= neg_s1;
			lvl_s2  <= lvl_s1;

			quot_s3 <= div_prod[capavg_pkg::CODE_DIV_SH +: QUOT_W];
			offs_s3 <= offs_s2;
			neg_s3  <= neg_s2;
			lvl_s3  <= lvl_s2;

			cap_s4 <= cap_nxt;
			lvl_s4 <= lvl_s3;

			cap_s5 <= cap_s4;
			lvl_s5 <= lvl_s4;
			cap_s6 <= cap_s5;
			lvl_s6 <= lvl_s5;
			cap_s7 <= cap_s6;
			lvl_s7 <= lvl_s6;
		end
	end

	// Window unit: stages 5 to 7 run the sum and the average.
	assign win_ctrl.adv  = adv;
	assign win_ctrl.push = v_s4 && adv;

	capavg_window #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.cap     (cap_s4),
		.average (average)
	);

	// Sensor configuration and trigger words.
	assign cfg_word_nxt =
		(WORD_W'(sensor_channel_q) << capavg_pkg::CFG_CHAN_SHIFT) |
		(WORD_W'(capavg_pkg::CFG_FIXED_CODE) << capavg_pkg::CFG_FIXED_SHIFT) |
		(WORD_W'(lvl_s7) << capavg_pkg::CFG_LEVEL_SHIFT);
	assign trig_word_nxt =
		(WORD_W'(sample_rate_code_q) << capavg_pkg::TRIG_RATE_SHIFT) |
		(WORD_W'(1) << (capavg_pkg::TRIG_BIT_TOP - 3'(sensor_channel_q)));

	// Result register.
	always_ff @(posedge clk) begin
		if (adv) begin
			cap_out_q   <= cap_s7;
			avg_out_q   <= average;
			lvl_out_q   <= lvl_s7;
			cfg_word_q  <= cfg_word_nxt;
			trig_word_q <= trig_word_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign capacitance_ff    = cap_out_q;
	assign average_ff        = avg_out_q;
	assign offset_level_next = lvl_out_q;
	assign config_word       = cfg_word_q;
	assign trigger_word      = trig_word_q;

endmodule
